// ----- src/kwsm_pkg.sv -----
// shared constants, types and the address helper for the k-way sorted merge unit
// no dependencies; used by every module of the block
package kwsm_pkg;

   localparam int NUM_LISTS   = 8;
   localparam int LIST_DEPTH  = 8;
   localparam int VALUE_W     = 32;
   localparam int LIST_ID_W   = 3;
   localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;
   localparam int LIST_W      = $clog2(NUM_LISTS);
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
   localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [LIST_W-1:0]         list_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [TOT_W-1:0]          tot_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   // request action codes
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_MERGE = 1'b1;

   // flat slot address of element idx of a list
   function automatic addr_type store_addr(list_type list, cnt_type idx);
      store_addr = addr_type'(list) * addr_type'(LIST_DEPTH) + addr_type'(idx);
   endfunction

endpackage

// ----- src/kwsm_store.sv -----
// element memory: one write port, one read port with registered read data
// depends on kwsm_pkg
module kwsm_store (
   input  logic                clock,
   input  logic                wr_en,
   input  kwsm_pkg::addr_type  wr_addr,
   input  kwsm_pkg::value_type wr_data,
   input  logic                rd_en,
   input  kwsm_pkg::addr_type  rd_addr,
   output kwsm_pkg::value_type rd_data
);

   kwsm_pkg::value_type mem_ff [kwsm_pkg::STORE_DEPTH];
   kwsm_pkg::value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/kwsm_cmp.sv -----
// shared signed compare unit: decides whether a candidate head beats the current best
// depends on kwsm_pkg
module kwsm_cmp (
   input  kwsm_pkg::value_type cand_value,
   input  kwsm_pkg::value_type best_value,
   input  logic                best_valid,
   output logic                take
);

   // strict less-than keeps the lower list number on ties
   assign take = !best_valid || (cand_value < best_value);

endmodule

// ----- src/k_way_sorted_merge_unit.sv -----
// top level of the k-way sorted merge unit: sequencer, list counters and output register
// depends on kwsm_pkg, kwsm_store and kwsm_cmp
//
// A load request appends one signed value to the list named by req_list_id. Loads to
// a full list are dropped and set a sticky overflow flag, loads to a list number
// beyond the configured count are ignored. A merge request emits every held value in
// ascending order, lower list number first on ties, then clears all lists and the flag.
// Each merge result is found by scanning the head of every list through the single
// compare unit and the one read port of the element memory, then folding the last head
// read in ST_FINISH. The result waits in the output register while rsp_ready is low,
// and the next scan starts only once it is taken. A merge with nothing loaded gives one
// result flagged empty. The block accepts no request while a merge is running.
module k_way_sorted_merge_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [kwsm_pkg::LIST_ID_W-1:0]       req_list_id,
   input  logic signed [kwsm_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [kwsm_pkg::VALUE_W-1:0]  rsp_value_res,
   output logic                                 rsp_last,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_overflowed
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   kwsm_pkg::cnt_type   fill_ff [kwsm_pkg::NUM_LISTS];
   kwsm_pkg::cnt_type   fill_in [kwsm_pkg::NUM_LISTS];
   kwsm_pkg::cnt_type   pos_ff  [kwsm_pkg::NUM_LISTS];
   kwsm_pkg::cnt_type   pos_in  [kwsm_pkg::NUM_LISTS];
   kwsm_pkg::tot_type   total_ff, total_in;
   kwsm_pkg::tot_type   sent_ff, sent_in;
   logic                drop_ff, drop_in;
   kwsm_pkg::list_type  scan_idx_ff, scan_idx_in;
   logic                pend_valid_ff, pend_valid_in;
   kwsm_pkg::list_type  pend_list_ff, pend_list_in;
   logic                best_valid_ff, best_valid_in;
   kwsm_pkg::list_type  best_list_ff, best_list_in;
   kwsm_pkg::value_type best_val_ff, best_val_in;
   kwsm_pkg::value_type rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                wr_en;
   kwsm_pkg::addr_type  wr_addr;
   logic                rd_en;
   kwsm_pkg::addr_type  rd_addr;
   kwsm_pkg::value_type rd_data;
   logic                take;

   logic                req_fire;
   logic                rsp_fire;
   logic                lid_ok;
   kwsm_pkg::list_type  lid;

   kwsm_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kwsm_cmp u_cmp (
      .cand_value (rd_data),
      .best_value (best_val_ff),
      .best_valid (best_valid_ff),
      .take       (take)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign lid_ok = (int'(req_list_id) < kwsm_pkg::NUM_LISTS);
   assign lid    = kwsm_pkg::list_type'(req_list_id);

   assign wr_en   = req_fire && (req_action == kwsm_pkg::ACTION_LOAD) && lid_ok &&
                    (fill_ff[lid] < kwsm_pkg::cnt_type'(kwsm_pkg::LIST_DEPTH));
   assign wr_addr = kwsm_pkg::store_addr(lid, fill_ff[lid]);

   // head read for the list under scan
   assign rd_en   = (state_ff == ST_SCAN) && (pos_ff[scan_idx_ff] < fill_ff[scan_idx_ff]);
   assign rd_addr = kwsm_pkg::store_addr(scan_idx_ff, pos_ff[scan_idx_ff]);

   assign rsp_value_res  = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_empty_res  = rsp_empty_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      sent_in       = sent_ff;
      drop_in       = drop_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = 1'b0;
      pend_list_in  = scan_idx_ff;
      best_valid_in = best_valid_ff;
      best_list_in  = best_list_ff;
      best_val_in   = best_val_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      // fold in the head read in the previous cycle
      if (pend_valid_ff && take) begin
         best_valid_in = 1'b1;
         best_list_in  = pend_list_ff;
         best_val_in   = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == kwsm_pkg::ACTION_LOAD) begin
                  if (lid_ok) begin
                     if (wr_en) begin
                        fill_in[lid] = fill_ff[lid] + kwsm_pkg::cnt_type'(1);
                        total_in     = total_ff + kwsm_pkg::tot_type'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
               end else if (total_ff == '0) begin
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  rsp_ovf_in   = drop_ff;
                  state_in     = ST_OUT;
               end else begin
                  sent_in       = '0;
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            pend_valid_in = rd_en;
            pend_list_in  = scan_idx_ff;
            if (scan_idx_ff == kwsm_pkg::list_type'(kwsm_pkg::NUM_LISTS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + kwsm_pkg::list_type'(1);
            end
         end
         ST_FINISH: begin
            rsp_value_in = best_val_in;
            rsp_last_in  = ((sent_ff + kwsm_pkg::tot_type'(1)) == total_ff);
            rsp_empty_in = 1'b0;
            rsp_ovf_in   = drop_ff;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (rsp_last_ff) begin
                  for (int i = 0; i < kwsm_pkg::NUM_LISTS; i++) begin
                     fill_in[i] = '0;
                     pos_in[i]  = '0;
                  end
                  total_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  pos_in[best_list_ff] = pos_ff[best_list_ff] + kwsm_pkg::cnt_type'(1);
                  sent_in       = sent_ff + kwsm_pkg::tot_type'(1);
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         sent_ff       <= '0;
         drop_ff       <= 1'b0;
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         for (int i = 0; i < kwsm_pkg::NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         sent_ff       <= sent_in;
         drop_ff       <= drop_in;
         scan_idx_ff   <= scan_idx_in;
         pend_valid_ff <= pend_valid_in;
         best_valid_ff <= best_valid_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
      end
      pend_list_ff <= pend_list_in;
      best_list_ff <= best_list_in;
      best_val_ff  <= best_val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule
